// ===== src/ring_fifo_linear_resampler_core_defines.svh =====
// Assertion macros shared by the resampler RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef RING_FIFO_LINEAR_RESAMPLER_CORE_DEFINES_SVH
`define RING_FIFO_LINEAR_RESAMPLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define RFLR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("resampler assertion failed");
// Next-cycle implication, checked while out of reset.
`define RFLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("resampler assertion failed");
`else
`define RFLR_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define RFLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/rflr_pkg.sv =====
// Shared types and constants of the ring buffer linear resampler.
// Depends on nothing; used by every module of the block but rflr_ram.
package rflr_pkg;

    localparam int DEPTH       = 65536;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int RATIO_BITS  = 20;
    localparam int FILL_BITS   = 16;
    localparam int ADDR_BITS   = $clog2(DEPTH);
    localparam int ACC_BITS    = ((RATIO_BITS > FRAC_BITS) ? RATIO_BITS : FRAC_BITS) + 1;
    localparam int STEP_BITS   = ACC_BITS - FRAC_BITS;
    localparam int PROD_BITS   = SAMPLE_BITS + FRAC_BITS + 2;

    localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(16384);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_TICK = 1'b1
    } t_command;

    typedef struct packed {
        t_command                       command;
        logic signed [SAMPLE_BITS-1:0]  sample_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0]  audio_out;
        logic                           underrun;
        logic [FILL_BITS-1:0]           fill_level;
    } t_out_item;

    // Head of the command queue as seen by the back end.
    typedef struct packed {
        logic      valid;
        t_in_item  item;
    } t_cmd_req;

endpackage

// ===== src/rflr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module rflr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rflr_front.sv =====
// Front end: accepts items and holds them in a short command queue.
// Depends on rflr_pkg.
module rflr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rflr_pkg::t_in_item i_in_data,
    output rflr_pkg::t_cmd_req o_req,
    input  logic               i_deq
);

    rflr_pkg::t_in_item                r_slot [rflr_pkg::QUEUE_DEPTH];
    logic [rflr_pkg::QPTR_BITS-1:0]    r_wptr, n_wptr;
    logic [rflr_pkg::QPTR_BITS-1:0]    r_rptr, n_rptr;
    logic [rflr_pkg::QCNT_BITS-1:0]    r_count, n_count;
    logic                              enq, deq;

    localparam logic [rflr_pkg::QPTR_BITS-1:0] QLAST =
        rflr_pkg::QPTR_BITS'(rflr_pkg::QUEUE_DEPTH - 1);
    localparam logic [rflr_pkg::QCNT_BITS-1:0] QFULL =
        rflr_pkg::QCNT_BITS'(rflr_pkg::QUEUE_DEPTH);

    assign o_in_ready = (r_count != QFULL);
    assign enq        = i_in_valid && o_in_ready;
    assign deq        = i_deq && (r_count != '0);

    assign o_req.valid = (r_count != '0);
    assign o_req.item  = r_slot[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (enq) begin
            n_wptr = (r_wptr == QLAST) ? '0 : r_wptr + 1'b1;
        end
        if (deq) begin
            n_rptr = (r_rptr == QLAST) ? '0 : r_rptr + 1'b1;
        end
        if (enq && !deq) begin
            n_count = r_count + 1'b1;
        end else if (deq && !enq) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_slot[r_wptr] <= i_in_data;
        end
    end

endmodule

// ===== src/rflr_back.sv =====
// Back end: ring pointers, phase accumulator, interpolation and result register.
// Depends on rflr_pkg, rflr_ram and the assertion macro header.
`include "ring_fifo_linear_resampler_core_defines.svh"

module rflr_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rflr_pkg::RATIO_BITS-1:0]    i_cfg_data,
    input  rflr_pkg::t_cmd_req                 i_req,
    output logic                               o_deq,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output rflr_pkg::t_out_item                o_out_data
);

    localparam int AB = rflr_pkg::ADDR_BITS;
    localparam logic [AB-1:0] LAST   = AB'(rflr_pkg::DEPTH - 1);
    localparam logic [AB:0]   DEPTHW = (AB + 1)'(rflr_pkg::DEPTH);
    localparam logic [rflr_pkg::FILL_BITS-1:0] FILL_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HELD = 4'b0010,
        S_PEEK = 4'b0100,
        S_SUM  = 4'b1000
    } t_state;

    t_state                                   r_state, n_state;
    logic [AB-1:0]                            r_rp, n_rp;
    logic [AB-1:0]                            r_wp, n_wp;
    logic signed [rflr_pkg::SAMPLE_BITS-1:0]  r_held, n_held;
    logic [rflr_pkg::FRAC_BITS-1:0]           r_frac, n_frac;
    logic [rflr_pkg::RATIO_BITS-1:0]          r_ratio;
    logic                                     r_pop_any, n_pop_any;
    logic                                     r_empty, n_empty;
    logic signed [rflr_pkg::PROD_BITS-1:0]    r_prod, n_prod;
    logic [rflr_pkg::FILL_BITS-1:0]           r_fill, n_fill;
    logic                                     r_out_valid, n_out_valid;
    rflr_pkg::t_out_item                      r_out, n_out;

    logic [rflr_pkg::ACC_BITS-1:0]            acc;
    logic [rflr_pkg::STEP_BITS-1:0]           steps;
    logic [AB-1:0]                            fill_now;
    logic [AB-1:0]                            pops;
    logic [AB:0]                              rp_sum;
    logic [AB-1:0]                            rp_after;
    logic [AB-1:0]                            held_addr;
    logic [AB-1:0]                            wp_inc, rp_inc;
    logic                                     ram_we;
    logic [AB-1:0]                            ram_raddr;
    logic [rflr_pkg::SAMPLE_BITS-1:0]         ram_rdata;
    logic signed [rflr_pkg::SAMPLE_BITS-1:0]  next_sample;
    logic signed [rflr_pkg::SAMPLE_BITS:0]    diff;
    logic signed [rflr_pkg::FRAC_BITS:0]      frac_s;
    logic signed [rflr_pkg::PROD_BITS-1:0]    prod_shr;
    logic                                     out_free;
    logic                                     is_push, is_tick;
    logic                                     dry_tick;

    // Samples waiting between the two pointers.
    always_comb begin
        if (r_wp >= r_rp) begin
            fill_now = r_wp - r_rp;
        end else begin
            fill_now = AB'(DEPTHW - {1'b0, r_rp} + {1'b0, r_wp});
        end
    end

    assign wp_inc = (r_wp == LAST) ? '0 : r_wp + 1'b1;
    assign rp_inc = (r_rp == LAST) ? '0 : r_rp + 1'b1;

    // Phase step and the number of samples actually popped on this tick.
    assign acc   = rflr_pkg::ACC_BITS'(r_frac) + rflr_pkg::ACC_BITS'(r_ratio);
    assign steps = acc[rflr_pkg::ACC_BITS-1:rflr_pkg::FRAC_BITS];
    assign pops  = (32'(steps) < 32'(fill_now)) ? AB'(steps) : fill_now;

    // Read pointer after the pops, and the address of the last sample popped.
    always_comb begin
        rp_sum = {1'b0, r_rp} + {1'b0, pops};
        if (rp_sum >= DEPTHW) begin
            rp_after = AB'(rp_sum - DEPTHW);
        end else begin
            rp_after = rp_sum[AB-1:0];
        end
        held_addr = (rp_after == '0) ? LAST : rp_after - 1'b1;
    end

    assign is_push  = i_req.valid && (i_req.item.command == rflr_pkg::CMD_PUSH);
    assign is_tick  = i_req.valid && (i_req.item.command == rflr_pkg::CMD_TICK);
    assign out_free = !r_out_valid || i_out_ready;

    assign ram_we    = (r_state == S_IDLE) && is_push;
    assign ram_raddr = (r_state == S_IDLE) ? held_addr : r_rp;

    rflr_ram #(
        .WIDTH (rflr_pkg::SAMPLE_BITS),
        .DEPTH (rflr_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_req.item.sample_in),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Interpolation datapath: difference times fraction, then a floor shift.
    assign next_sample = r_empty ? r_held : $signed(ram_rdata);
    assign diff        = {next_sample[rflr_pkg::SAMPLE_BITS-1], next_sample}
                       - {r_held[rflr_pkg::SAMPLE_BITS-1], r_held};
    assign frac_s      = $signed({1'b0, r_frac});
    assign prod_shr    = r_prod >>> rflr_pkg::FRAC_BITS;

    always_comb begin
        n_state     = r_state;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_held      = r_held;
        n_frac      = r_frac;
        n_pop_any   = r_pop_any;
        n_empty     = r_empty;
        n_prod      = r_prod;
        n_fill      = r_fill;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_deq       = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (is_push) begin
                    o_deq = 1'b1;
                    n_wp  = wp_inc;
                    if (wp_inc == r_rp) begin
                        n_rp = rp_inc;
                    end
                end else if (is_tick) begin
                    o_deq     = 1'b1;
                    n_frac    = acc[rflr_pkg::FRAC_BITS-1:0];
                    n_pop_any = (pops != '0);
                    n_rp      = rp_after;
                    n_state   = S_HELD;
                end
            end
            S_HELD: begin
                if (r_pop_any) begin
                    n_held = $signed(ram_rdata);
                end
                n_empty = (r_rp == r_wp);
                n_state = S_PEEK;
            end
            S_PEEK: begin
                n_prod  = rflr_pkg::PROD_BITS'(diff * frac_s);
                n_fill  = (32'(fill_now) > 32'(FILL_MAX)) ? FILL_MAX
                                                          : rflr_pkg::FILL_BITS'(fill_now);
                n_state = S_SUM;
            end
            S_SUM: begin
                if (out_free) begin
                    n_out.audio_out  = prod_shr[rflr_pkg::SAMPLE_BITS-1:0] + r_held;
                    n_out.underrun   = r_empty;
                    n_out.fill_level = r_fill;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_held      <= '0;
            r_frac      <= '0;
            r_ratio     <= rflr_pkg::RATIO_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_held      <= n_held;
            r_frac      <= n_frac;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_ratio <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_any <= n_pop_any;
        r_empty   <= n_empty;
        r_prod    <= n_prod;
        r_fill    <= n_fill;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A tick taken while nothing is waiting.
    assign dry_tick = (r_state == S_IDLE) && is_tick && (fill_now == '0);

    // A push always leaves at least one sample waiting.
    `RFLR_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, ram_we, r_rp != r_wp)
    // With the buffer empty the next sample is the held one, so nothing is added.
    `RFLR_ASSERT_NOW(a_underrun_flat, i_clk, i_rst_n, (r_state == S_SUM) && r_empty, r_prod == '0)
    // A fresh result only ever comes out of the final interpolation step.
    `RFLR_ASSERT_NOW(a_result_src, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_SUM))
    // A tick moves the read pointer by no more than the samples waiting; with none waiting it stays put.
    `RFLR_ASSERT_NEXT(a_no_overrun, i_clk, i_rst_n, dry_tick, r_rp == $past(r_rp))

endmodule

// ===== src/ring_fifo_linear_resampler_core.sv =====
// A push is written while the back end is idle; a tick's result is registered after the back end
// steps through S_HELD, S_PEEK and S_SUM, the last waiting until the output register is free; items
// reach it through a two-entry queue. A push every cycle while the back end is idle; the tick states
// come from the two reads of the sample memory's single read port and the multiply's register.
// Reset (synchronous, active low) clears pointers, phase, held sample and the rate ratio to 0.25;
// the sample memory is not cleared, as only written entries are ever used.
module ring_fifo_linear_resampler_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  rflr_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rflr_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [rflr_pkg::RATIO_BITS-1:0]  i_cfg_data
);

    // The front end only buffers items; it lets the input side keep going while the
    // back end works through a tick or waits for its result to be taken.
    rflr_pkg::t_cmd_req req;
    logic               deq;

    rflr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_req      (req),
        .i_deq      (deq)
    );

    // The back end owns the ring pointers, the phase accumulator and the sample memory.
    // On a tick it pops the whole number of samples in one go, since only the last one
    // popped becomes the held sample, then reads the next sample for the interpolation.
    rflr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req),
        .o_deq       (deq),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== tb/tb_ring_fifo_linear_resampler_core.sv =====
// Self-checking testbench for the ring buffer linear resampler core.
// Depends on rflr_pkg and ring_fifo_linear_resampler_core; it predicts each output sample
// from its own copy of the ring, the pointers, the phase and the held sample.
module tb_ring_fifo_linear_resampler_core;

    localparam int CYCLE_LIMIT   = 1000000;
    // Cycles allowed after the last expected item before the block counts as idle.
    localparam int SETTLE_CYCLES = 12;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    rflr_pkg::t_in_item              in_item   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    rflr_pkg::t_out_item             out_item;
    logic                            cfg_we    = 1'b0;
    logic [rflr_pkg::RATIO_BITS-1:0] cfg_data  = '0;

    // Predicted state of the block.
    logic signed [rflr_pkg::SAMPLE_BITS-1:0] ring_copy [rflr_pkg::DEPTH];
    logic [rflr_pkg::ADDR_BITS-1:0]          rd_ptr     = '0;
    logic [rflr_pkg::ADDR_BITS-1:0]          wr_ptr     = '0;
    logic signed [rflr_pkg::SAMPLE_BITS-1:0] held_value = '0;
    logic [rflr_pkg::FRAC_BITS-1:0]          phase_acc  = '0;
    logic [rflr_pkg::RATIO_BITS-1:0]         step_ratio = rflr_pkg::RATIO_RESET;

    rflr_pkg::t_out_item pending_samples [$];
    int                  fail_count      = 0;
    int unsigned         cycle_count     = 0;
    int                  send_idle_pct   = 0;
    int                  recv_stall_pct  = 0;
    int                  rx_hold_request = 0;
    int                  rx_hold_left    = 0;

    ring_fifo_linear_resampler_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // A push into a full ring drops the oldest sample.
    function automatic void ring_push_sample(input logic signed [rflr_pkg::SAMPLE_BITS-1:0] s);
        ring_copy[wr_ptr] = s;
        wr_ptr = wr_ptr + 1'b1;
        if (wr_ptr == rd_ptr)
            rd_ptr = rd_ptr + 1'b1;
    endfunction

    // Advances the phase, pops whole steps into the held sample and interpolates towards
    // the next waiting sample; the shift floors, so negative slopes round downwards.
    function automatic rflr_pkg::t_out_item resample_tick();
        logic [rflr_pkg::ACC_BITS-1:0]           acc;
        int unsigned                             pops;
        logic                                    empty;
        logic signed [rflr_pkg::SAMPLE_BITS-1:0] next_value;
        logic signed [rflr_pkg::SAMPLE_BITS:0]   slope;
        logic signed [rflr_pkg::PROD_BITS-1:0]   prod;
        logic signed [rflr_pkg::PROD_BITS-1:0]   interp;
        rflr_pkg::t_out_item                     res;
        acc = rflr_pkg::ACC_BITS'(phase_acc) + rflr_pkg::ACC_BITS'(step_ratio);
        pops = acc >> rflr_pkg::FRAC_BITS;
        phase_acc = acc[rflr_pkg::FRAC_BITS-1:0];
        for (int i = 0; i < pops; i++) begin
            if (rd_ptr != wr_ptr) begin
                held_value = ring_copy[rd_ptr];
                rd_ptr = rd_ptr + 1'b1;
            end
        end
        empty = (rd_ptr == wr_ptr);
        next_value = empty ? held_value : ring_copy[rd_ptr];
        slope = next_value - held_value;
        prod = slope * $signed({1'b0, phase_acc});
        interp = (prod >>> rflr_pkg::FRAC_BITS) + held_value;
        res.audio_out = interp[rflr_pkg::SAMPLE_BITS-1:0];
        res.underrun = empty;
        res.fill_level = rflr_pkg::FILL_BITS'(wr_ptr - rd_ptr);
        return res;
    endfunction

    // Output side: random stalls, long hold-offs on request, and the result check.
    always @(posedge clk) begin
        rflr_pkg::t_out_item want;
        if (rx_hold_request != 0) begin
            rx_hold_left = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
        if (rst_n && out_valid && out_ready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected output item: audio_out %0d", out_item.audio_out);
                fail_count++;
            end else begin
                want = pending_samples.pop_front();
                if (out_item.audio_out !== want.audio_out) begin
                    $error("audio_out: expected %0d, got %0d", want.audio_out,
                           out_item.audio_out);
                    fail_count++;
                end
                if (out_item.underrun !== want.underrun) begin
                    $error("underrun: expected %0d, got %0d", want.underrun,
                           out_item.underrun);
                    fail_count++;
                end
                if (out_item.fill_level !== want.fill_level) begin
                    $error("fill_level: expected %0d, got %0d", want.fill_level,
                           out_item.fill_level);
                    fail_count++;
                end
            end
        end
    end

    // Offers one item and waits for it to be taken. Entered and left just after a
    // rising edge, so valid stays high between back-to-back items. Each cycle before
    // the offer is idle with the sender's idle percentage.
    task automatic send_item(input rflr_pkg::t_command cmd,
                             input logic signed [rflr_pkg::SAMPLE_BITS-1:0] s);
        rflr_pkg::t_in_item item;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        item.command = cmd;
        item.sample_in = s;
        in_valid <= 1'b1;
        in_item <= item;
        do @(posedge clk); while (!in_ready);
        if (cmd == rflr_pkg::CMD_PUSH)
            ring_push_sample(s);
        else
            pending_samples.push_back(resample_tick());
    endtask

    task automatic wait_until_quiet();
        in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_rate_ratio(input logic [rflr_pkg::RATIO_BITS-1:0] r);
        wait_until_quiet();
        cfg_we <= 1'b1;
        cfg_data <= r;
        @(posedge clk);
        cfg_we <= 1'b0;
        step_ratio = r;
    endtask

    // Underrun from reset, full-scale samples, both slope signs and the ratio extremes.
    task automatic test_directed();
        send_item(rflr_pkg::CMD_TICK, 16'sd0);
        send_item(rflr_pkg::CMD_PUSH, 16'sh7FFF);
        send_item(rflr_pkg::CMD_PUSH, 16'sh8000);
        repeat (4) send_item(rflr_pkg::CMD_TICK, 16'sd0);
        set_rate_ratio(20'hFFFFF);
        send_item(rflr_pkg::CMD_TICK, 16'sd0);
        send_item(rflr_pkg::CMD_TICK, 16'sd0);
        set_rate_ratio(20'h00000);
        send_item(rflr_pkg::CMD_PUSH, 16'sd0);
        send_item(rflr_pkg::CMD_PUSH, -16'sd1);
        send_item(rflr_pkg::CMD_PUSH, 16'sd1);
        send_item(rflr_pkg::CMD_PUSH, 16'sh7FFF);
        send_item(rflr_pkg::CMD_TICK, 16'sd0);
        send_item(rflr_pkg::CMD_TICK, 16'sh7FFF);
        set_rate_ratio(20'h18000);
        repeat (4) send_item(rflr_pkg::CMD_TICK, 16'sd0);
        set_rate_ratio(20'h04000);
        send_item(rflr_pkg::CMD_PUSH, 16'sh8000);
        send_item(rflr_pkg::CMD_PUSH, 16'sh7FFF);
        send_item(rflr_pkg::CMD_TICK, 16'sd0);
        send_item(rflr_pkg::CMD_TICK, 16'sd0);
    endtask

    // Mixed traffic; pushes come at about the rate the ticks drain them, so the ring
    // hovers between empty and a few entries, with some noise on the command mix.
    task automatic send_random_burst(input int count);
        rflr_pkg::t_command cmd;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 20)
                cmd = rflr_pkg::t_command'($urandom_range(0, 1));
            else if ($urandom_range(0, 65535 + step_ratio) < step_ratio)
                cmd = rflr_pkg::CMD_PUSH;
            else
                cmd = rflr_pkg::CMD_TICK;
            send_item(cmd, rflr_pkg::SAMPLE_BITS'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 33;
        recv_stall_pct = 80;
        set_rate_ratio(rflr_pkg::RATIO_BITS'($urandom_range(1, 32767)));
        send_random_burst(80);
        set_rate_ratio(20'h10000);
        send_random_burst(80);
        send_idle_pct = 80;
        recv_stall_pct = 33;
        set_rate_ratio(20'hFFFFF);
        send_random_burst(80);
        set_rate_ratio(20'h00000);
        send_random_burst(80);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_rate_ratio(rflr_pkg::RATIO_BITS'($urandom_range(0, 1048575)));
        send_random_burst(80);
        set_rate_ratio(rflr_pkg::RATIO_BITS'($urandom_range(8192, 131072)));
        send_random_burst(80);
    endtask

    // The output side holds off for a long stretch while items keep coming, so the
    // block has to stop taking input until the results drain.
    task automatic test_input_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_rate_ratio(20'd40000);
        rx_hold_request = 400;
        for (int i = 0; i < 40; i++)
            send_item(($urandom_range(0, 3) == 0) ? rflr_pkg::CMD_PUSH : rflr_pkg::CMD_TICK,
                      rflr_pkg::SAMPLE_BITS'($urandom));
    endtask

    // Fills the ring with a few dozen samples, checks a few single steps, then drains
    // it at the largest ratio, many samples per tick, until it runs dry.
    task automatic test_ring_drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_rate_ratio(20'h10000);
        for (int i = 0; i < 48; i++)
            send_item(rflr_pkg::CMD_PUSH, rflr_pkg::SAMPLE_BITS'($urandom));
        repeat (4) send_item(rflr_pkg::CMD_TICK, 16'sd0);
        set_rate_ratio(20'hFFFFF);
        while (rd_ptr != wr_ptr)
            send_item(rflr_pkg::CMD_TICK, 16'sd0);
        send_item(rflr_pkg::CMD_TICK, 16'sd0);
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic();
        test_input_backpressure();
        test_ring_drain();
        wait_until_quiet();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
